// File: design/epc_pkg.sv
// shared types, constants and calendar helpers for the epoch to calendar converter
package epc_pkg;

  localparam int unsigned SecW  = 32;
  localparam int unsigned DaysW = 16;
  localparam int unsigned TodW  = 17;
  localparam int unsigned RemW  = 12;
  localparam int unsigned LenW  = 9;
  localparam int unsigned MulW  = 26;

  // quotient = ((x >> pre) * rcp) >> shift, exact over each operand range
  localparam int unsigned DAY_PRE   = 7;
  localparam int unsigned DAY_SHIFT = 35;
  localparam int unsigned WK_SHIFT  = 19;
  localparam int unsigned HR_PRE    = 4;
  localparam int unsigned HR_SHIFT  = 21;
  localparam int unsigned MN_PRE    = 2;
  localparam int unsigned MN_SHIFT  = 14;

  localparam logic [MulW-1:0] DAY_RCP = MulW'(50903317);
  localparam logic [MulW-1:0] WK_RCP  = MulW'(74899);
  localparam logic [MulW-1:0] HR_RCP  = MulW'(9321);
  localparam logic [MulW-1:0] MN_RCP  = MulW'(1093);

  localparam logic [MulW-1:0] SECS_DAY  = MulW'(86400);
  localparam logic [MulW-1:0] SECS_HOUR = MulW'(3600);
  localparam logic [MulW-1:0] SECS_MIN  = MulW'(60);
  localparam logic [MulW-1:0] DAYS_WEEK = MulW'(7);

  localparam logic [7:0] CENTURY_2100 = 8'd100;
  localparam logic [3:0] FEBRUARY     = 4'd2;
  localparam logic [3:0] AUGUST       = 4'd8;
  localparam logic [3:0] DECEMBER     = 4'd12;

  typedef struct packed {
    logic            ge;
    logic [SecW-1:0] diff;
  } alu_res_t;

  // offsets 0..136 from 2000: only 2100 is a non-leap multiple of four
  function automatic logic is_leap(input logic [7:0] yoff);
    return (yoff[1:0] == 2'b00) && (yoff != CENTURY_2100);
  endfunction

  function automatic logic [LenW-1:0] year_len(input logic [7:0] yoff);
    return is_leap(yoff) ? LenW'(366) : LenW'(365);
  endfunction

  function automatic logic [LenW-1:0] month_len(input logic [7:0] yoff, input logic [3:0] m);
    logic [LenW-1:0] len;
    if (m == FEBRUARY) begin
      len = is_leap(yoff) ? LenW'(29) : LenW'(28);
    end else if (m < AUGUST) begin
      len = m[0] ? LenW'(31) : LenW'(30);
    end else begin
      len = m[0] ? LenW'(30) : LenW'(31);
    end
    return len;
  endfunction

endpackage

// File: design/epc_alu.sv
// shared compare and subtract unit
module epc_alu (
  input  logic [epc_pkg::SecW-1:0] a,
  input  logic [epc_pkg::SecW-1:0] b,
  output epc_pkg::alu_res_t        res
);
  import epc_pkg::*;

  logic [SecW:0] wide;

  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~wide[SecW];
  assign res.diff = wide[SecW-1:0];

endmodule

// File: design/epoch_seconds_to_calendar_core.sv
// top level: sequencer around one shared subtractor turning epoch seconds into calendar fields
//
// usage: present in_epoch_seconds with start while busy is low; that edge is the
// input transfer and busy rises in the next cycle. all work runs through one
// 32-bit compare and subtract unit and one 26 by 26 bit multiplier under a small sequencer:
//   3 steps each for days, days modulo 7, hours and minutes
//   (reciprocal multiply, multiply back, subtract the product)
//   one step per year peeled plus one, up to 137
//   one step per month peeled plus one, up to 12
// the result shows after the year and month loops, whose step counts vary with the input.
// the next item can be taken in the cycle the result is shown; start is ignored while
// busy is high, so a new item is not taken before the last one is through.
// the result appears on the out_ ports for exactly one cycle with out_valid high;
// the receiver cannot stall, and the fields change while the next item is worked on.
// reset (rst_n low at a clock edge) returns the sequencer to idle and drops
// out_valid; no memory needs clearing.
module epoch_seconds_to_calendar_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [epc_pkg::SecW-1:0] in_epoch_seconds,
  output logic                     out_valid,
  output logic [7:0]               out_year_offset,
  output logic [3:0]               out_month,
  output logic [4:0]               out_day_of_month,
  output logic [4:0]               out_hour,
  output logic [5:0]               out_minute,
  output logic [5:0]               out_second,
  output logic [2:0]               out_weekday
);
  import epc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DAYQ  = 4'd1;
  localparam logic [3:0] S_DAYP  = 4'd2;
  localparam logic [3:0] S_DAYR  = 4'd3;
  localparam logic [3:0] S_WKQ   = 4'd4;
  localparam logic [3:0] S_WKP   = 4'd5;
  localparam logic [3:0] S_WKR   = 4'd6;
  localparam logic [3:0] S_YEAR  = 4'd7;
  localparam logic [3:0] S_MONTH = 4'd8;
  localparam logic [3:0] S_HRQ   = 4'd9;
  localparam logic [3:0] S_HRP   = 4'd10;
  localparam logic [3:0] S_HRR   = 4'd11;
  localparam logic [3:0] S_MNQ   = 4'd12;
  localparam logic [3:0] S_MNP   = 4'd13;
  localparam logic [3:0] S_MNR   = 4'd14;

  logic [3:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SecW-1:0]  acc_r, acc_nxt;
  logic [SecW-1:0]  prod_r, prod_nxt;
  logic [DaysW-1:0] quo_r, quo_nxt;
  logic [DaysW-1:0] days_r, days_nxt;
  logic [TodW-1:0]  tod_r, tod_nxt;
  logic [7:0]       year_r, year_nxt;
  logic [3:0]       month_r, month_nxt;
  logic [4:0]       dom_r, dom_nxt;
  logic [4:0]       hour_r, hour_nxt;
  logic [5:0]       minute_r, minute_nxt;
  logic [5:0]       second_r, second_nxt;
  logic [2:0]       wd_r, wd_nxt;

  logic [SecW-1:0]   b_op;
  alu_res_t          alu_res;
  logic [MulW-1:0]   mul_a;
  logic [MulW-1:0]   mul_b;
  logic [2*MulW-1:0] mul_p;

  always_comb begin
    unique case (state_r)
      S_YEAR:  b_op = SecW'(year_len(year_r));
      S_MONTH: b_op = SecW'(month_len(year_r, month_r));
      default: b_op = prod_r;
    endcase
  end

  epc_alu u_alu (
    .a   (acc_r),
    .b   (b_op),
    .res (alu_res)
  );

  always_comb begin
    unique case (state_r)
      S_DAYQ: begin
        mul_a = MulW'(acc_r[SecW-1:DAY_PRE]);
        mul_b = DAY_RCP;
      end
      S_DAYP: begin
        mul_a = MulW'(days_r);
        mul_b = SECS_DAY;
      end
      S_WKQ: begin
        mul_a = MulW'(days_r);
        mul_b = WK_RCP;
      end
      S_WKP: begin
        mul_a = MulW'(quo_r);
        mul_b = DAYS_WEEK;
      end
      S_HRQ: begin
        mul_a = MulW'(acc_r[TodW-1:HR_PRE]);
        mul_b = HR_RCP;
      end
      S_HRP: begin
        mul_a = MulW'(hour_r);
        mul_b = SECS_HOUR;
      end
      S_MNQ: begin
        mul_a = MulW'(acc_r[RemW-1:MN_PRE]);
        mul_b = MN_RCP;
      end
      S_MNP: begin
        mul_a = MulW'(minute_r);
        mul_b = SECS_MIN;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = (2*MulW)'(mul_a) * (2*MulW)'(mul_b);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    quo_nxt       = quo_r;
    days_nxt      = days_r;
    tod_nxt       = tod_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    dom_nxt       = dom_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    wd_nxt        = wd_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          acc_nxt   = in_epoch_seconds;
          state_nxt = S_DAYQ;
        end
      end
      S_DAYQ: begin
        days_nxt  = mul_p[DAY_SHIFT +: DaysW];
        state_nxt = S_DAYP;
      end
      S_DAYP: begin
        prod_nxt  = mul_p[SecW-1:0];
        state_nxt = S_DAYR;
      end
      S_DAYR: begin
        tod_nxt   = alu_res.diff[TodW-1:0];
        acc_nxt   = SecW'(days_r);
        state_nxt = S_WKQ;
      end
      S_WKQ: begin
        quo_nxt   = mul_p[WK_SHIFT +: DaysW];
        state_nxt = S_WKP;
      end
      S_WKP: begin
        prod_nxt  = mul_p[SecW-1:0];
        state_nxt = S_WKR;
      end
      S_WKR: begin
        // day zero was a saturday
        wd_nxt    = (alu_res.diff[2:0] == 3'd0) ? 3'd6 : alu_res.diff[2:0] - 3'd1;
        year_nxt  = '0;
        state_nxt = S_YEAR;
      end
      S_YEAR: begin
        if (alu_res.ge) begin
          acc_nxt  = alu_res.diff;
          year_nxt = year_r + 8'd1;
        end else begin
          month_nxt = 4'd1;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (alu_res.ge && (month_r != DECEMBER)) begin
          acc_nxt   = alu_res.diff;
          month_nxt = month_r + 4'd1;
        end else begin
          dom_nxt   = acc_r[4:0] + 5'd1;
          acc_nxt   = SecW'(tod_r);
          state_nxt = S_HRQ;
        end
      end
      S_HRQ: begin
        hour_nxt  = mul_p[HR_SHIFT +: 5];
        state_nxt = S_HRP;
      end
      S_HRP: begin
        prod_nxt  = mul_p[SecW-1:0];
        state_nxt = S_HRR;
      end
      S_HRR: begin
        acc_nxt   = alu_res.diff;
        state_nxt = S_MNQ;
      end
      S_MNQ: begin
        minute_nxt = mul_p[MN_SHIFT +: 6];
        state_nxt  = S_MNP;
      end
      S_MNP: begin
        prod_nxt  = mul_p[SecW-1:0];
        state_nxt = S_MNR;
      end
      S_MNR: begin
        second_nxt    = alu_res.diff[5:0];
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    quo_r    <= quo_nxt;
    days_r   <= days_nxt;
    tod_r    <= tod_nxt;
    year_r   <= year_nxt;
    month_r  <= month_nxt;
    dom_r    <= dom_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    second_r <= second_nxt;
    wd_r     <= wd_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_year_offset  = year_r;
  assign out_month        = month_r;
  assign out_day_of_month = dom_r;
  assign out_hour         = hour_r;
  assign out_minute       = minute_r;
  assign out_second       = second_r;
  assign out_weekday      = wd_r;

  // a transfer always starts the sequencer
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("transfer did not start the sequencer");

  // results never come back to back
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // the month search never leaves the calendar range
  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_MONTH) |-> (month_r >= 4'd1 && month_r <= DECEMBER))
    else $error("month out of range during month search");

  // a finished result carries a legal date
  assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (!busy && out_day_of_month != 5'd0 && out_hour <= 5'd23 &&
                     out_weekday <= 3'd6 && out_year_offset <= 8'd136))
    else $error("result fields out of range");

endmodule
